[rtl/core/rcm_pkg.sv]
// shared types and constants for the rounded corner mask core
`timescale 1ns / 1ps

package rcm_pkg;

   localparam int DIM_W    = 13;
   localparam int RADIUS_W = 12;
   localparam int COORD_W  = 12;
   localparam int PIXEL_W  = 32;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 13;

   localparam logic [DIM_W-1:0] WIDTH_RESET  = 13'd640;
   localparam logic [DIM_W-1:0] HEIGHT_RESET = 13'd480;
   localparam logic [RADIUS_W-1:0] RADIUS_RESET = 12'd0;

   localparam int FADE_STEPS = 32;
   localparam int FADE_SHIFT = 5;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_WIDTH  = 2'd0,
      CSR_HEIGHT = 2'd1,
      CSR_RADIUS = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [DIM_W-1:0]    width;
      logic [DIM_W-1:0]    height;
      logic [RADIUS_W-1:0] radius;
   } cfg_type;

   typedef enum logic [1:0] {
      SEL_PASS = 2'd0,
      SEL_FADE = 2'd1,
      SEL_ZERO = 2'd2
   } sel_type;

endpackage

[rtl/core/rcm_pipe.sv]
// six stage pixel pipeline computing the rounded corner mask
`timescale 1ns / 1ps

module rcm_pipe #(
   parameter int MAX_DIM = 4096
) (
   input  logic                           clock,
   input  logic                           reset,
   input  rcm_pkg::cfg_type               cfg,
   input  logic                           in_valid,
   input  logic [rcm_pkg::PIXEL_W-1:0]    in_pixel,
   input  logic [rcm_pkg::COORD_W-1:0]    in_col,
   input  logic [rcm_pkg::COORD_W-1:0]    in_row,
   output logic                           out_valid,
   output logic [rcm_pkg::PIXEL_W-1:0]    out_pixel
);

   localparam int DW = rcm_pkg::DIM_W;
   localparam int RW = rcm_pkg::RADIUS_W;
   localparam int CW = rcm_pkg::COORD_W;
   localparam int PW = rcm_pkg::PIXEL_W;
   localparam int SQ_W = 2 * RW;
   localparam int D_W = SQ_W + 1;
   localparam int E_W = rcm_pkg::FADE_SHIFT;
   localparam int K_W = rcm_pkg::FADE_SHIFT + 1;
   localparam int DIM_MAX_VAL = (1 << DW) - 1;
   localparam logic [DW-1:0] MAX_DIM_C =
      (MAX_DIM > DIM_MAX_VAL) ? DW'(DIM_MAX_VAL) : DW'(MAX_DIM);

   typedef struct packed {
      logic [PW-1:0] pixel;
      logic [CW-1:0] col;
      logic [CW-1:0] row;
      logic [DW-1:0] w;
      logic [DW-1:0] h;
      logic [RW-1:0] r;
   } s1_type;

   typedef struct packed {
      logic [PW-1:0] pixel;
      logic [CW-1:0] col;
      logic [CW-1:0] row;
      logic [RW-1:0] r;
      logic [DW-1:0] hr;
      logic [DW-1:0] wr;
      logic          top;
      logic          left;
      logic          row_in;
      logic          col_in;
   } s2_type;

   typedef struct packed {
      logic [PW-1:0] pixel;
      logic [RW-1:0] r;
      logic [RW-1:0] dy;
      logic [RW-1:0] dx;
      logic          corner;
   } s3_type;

   typedef struct packed {
      logic [PW-1:0]   pixel;
      logic [SQ_W-1:0] dy2;
      logic [SQ_W-1:0] dx2;
      logic [SQ_W-1:0] r2;
      logic            corner;
   } s4_type;

   typedef struct packed {
      logic [PW-1:0]     pixel;
      rcm_pkg::sel_type  sel;
      logic [K_W-1:0]    k;
   } s5_type;

   logic   v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff;
   s1_type s1_ff, s1_in;
   s2_type s2_ff, s2_in;
   s3_type s3_ff, s3_in;
   s4_type s4_ff, s4_in;
   s5_type s5_ff, s5_in;
   logic [PW-1:0] pix_ff, pix_in;

   // stage 1: clamp dimensions and radius
   logic [DW-1:0] w_sat, h_sat;
   logic [RW-1:0] half_w, half_h, half;

   always_comb begin
      w_sat  = (cfg.width > MAX_DIM_C) ? MAX_DIM_C : cfg.width;
      h_sat  = (cfg.height > MAX_DIM_C) ? MAX_DIM_C : cfg.height;
      half_w = w_sat[DW-1:1];
      half_h = h_sat[DW-1:1];
      half   = (half_w < half_h) ? half_w : half_h;
      s1_in.pixel = in_pixel;
      s1_in.col   = in_col;
      s1_in.row   = in_row;
      s1_in.w     = w_sat;
      s1_in.h     = h_sat;
      s1_in.r     = (cfg.radius > half) ? half : cfg.radius;
   end

   // stage 2: far edges and near side flags
   always_comb begin
      s2_in.pixel  = s1_ff.pixel;
      s2_in.col    = s1_ff.col;
      s2_in.row    = s1_ff.row;
      s2_in.r      = s1_ff.r;
      s2_in.hr     = s1_ff.h - DW'(s1_ff.r);
      s2_in.wr     = s1_ff.w - DW'(s1_ff.r);
      s2_in.top    = s1_ff.row < s1_ff.r;
      s2_in.left   = s1_ff.col < s1_ff.r;
      s2_in.row_in = DW'(s1_ff.row) < s1_ff.h;
      s2_in.col_in = DW'(s1_ff.col) < s1_ff.w;
   end

   // stage 3: corner membership and offsets
   logic          bottom, right;
   logic [DW-1:0] dy_far, dx_far;

   always_comb begin
      bottom = s2_ff.row_in && (DW'(s2_ff.row) >= s2_ff.hr);
      right  = s2_ff.col_in && (DW'(s2_ff.col) >= s2_ff.wr);
      dy_far = DW'(s2_ff.row) - s2_ff.hr;
      dx_far = DW'(s2_ff.col) - s2_ff.wr;
      s3_in.pixel  = s2_ff.pixel;
      s3_in.r      = s2_ff.r;
      s3_in.dy     = s2_ff.top ? (s2_ff.r - s2_ff.row) : dy_far[RW-1:0];
      s3_in.dx     = s2_ff.left ? (s2_ff.r - s2_ff.col) : dx_far[RW-1:0];
      s3_in.corner = (s2_ff.r != '0) && (s2_ff.top || bottom) && (s2_ff.left || right);
   end

   // stage 4: squares
   always_comb begin
      s4_in.pixel  = s3_ff.pixel;
      s4_in.dy2    = SQ_W'(s3_ff.dy) * SQ_W'(s3_ff.dy);
      s4_in.dx2    = SQ_W'(s3_ff.dx) * SQ_W'(s3_ff.dx);
      s4_in.r2     = SQ_W'(s3_ff.r) * SQ_W'(s3_ff.r);
      s4_in.corner = s3_ff.corner;
   end

   // stage 5: distance compare and fade factor
   logic [D_W-1:0] dist_sum, r2_ext, excess;

   always_comb begin
      dist_sum = D_W'(s4_ff.dy2) + D_W'(s4_ff.dx2);
      r2_ext   = D_W'(s4_ff.r2);
      excess   = dist_sum - r2_ext;
      s5_in.pixel = s4_ff.pixel;
      s5_in.k     = K_W'(rcm_pkg::FADE_STEPS) - K_W'(excess[E_W-1:0]);
      if (!s4_ff.corner || dist_sum < r2_ext) begin
         s5_in.sel = rcm_pkg::SEL_PASS;
      end else if (dist_sum < r2_ext + D_W'(rcm_pkg::FADE_STEPS)) begin
         s5_in.sel = rcm_pkg::SEL_FADE;
      end else begin
         s5_in.sel = rcm_pkg::SEL_ZERO;
      end
   end

   // stage 6: per channel scaling
   logic [7+K_W:0] chan_prod [4];

   always_comb begin
      for (int c = 0; c < 4; c++) begin
         chan_prod[c] = (8+K_W)'(s5_ff.pixel[c*8 +: 8]) * (8+K_W)'(s5_ff.k);
      end
      case (s5_ff.sel)
         rcm_pkg::SEL_PASS: pix_in = s5_ff.pixel;
         rcm_pkg::SEL_FADE: begin
            for (int c = 0; c < 4; c++) begin
               pix_in[c*8 +: 8] = chan_prod[c][rcm_pkg::FADE_SHIFT +: 8];
            end
         end
         default: pix_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_ff  <= s1_in;
      s2_ff  <= s2_in;
      s3_ff  <= s3_in;
      s4_ff  <= s4_in;
      s5_ff  <= s5_in;
      pix_ff <= pix_in;
   end

   assign out_valid = v6_ff;
   assign out_pixel = pix_ff;

   a_latency: assert property (@(posedge clock) disable iff (reset)
      in_valid |-> ##6 out_valid)
      else $error("transfer did not reach the output after six stages");

   a_offset_range: assert property (@(posedge clock) disable iff (reset)
      (v3_ff && s3_ff.corner) |-> (s3_ff.dy <= s3_ff.r && s3_ff.dx <= s3_ff.r))
      else $error("corner offset exceeds radius");

   a_fade_factor: assert property (@(posedge clock) disable iff (reset)
      (v5_ff && s5_ff.sel == rcm_pkg::SEL_FADE) |->
         (s5_ff.k >= K_W'(1) && s5_ff.k <= K_W'(rcm_pkg::FADE_STEPS)))
      else $error("fade factor out of range");

   a_zero_radius: assert property (@(posedge clock) disable iff (reset)
      (v3_ff && s3_ff.r == '0) |-> !s3_ff.corner)
      else $error("zero radius flagged as corner");

endmodule

[rtl/core/rounded_corner_mask_core.sv]
// top level of the rounded corner mask core: config registers and pixel pipeline
//
//  channel  | ports                                   | handshake
//  ---------+-----------------------------------------+--------------------------
//  request  | start, busy, req_pixel_in/col/row       | start && !busy
//  response | rsp_valid, rsp_pixel_out                | one cycle strobe
//  config   | csr_valid, csr_ready, csr_index/data    | csr_valid && csr_ready
//
//  one pixel per clock, strobe raised once the request transfer has passed
//  through the six pipeline registers to the response
//  busy is never raised, the pipeline has no stall path
//  synchronous reset clears valid bits and restores 640 x 480, radius 0
`timescale 1ns / 1ps

module rounded_corner_mask_core #(
   parameter int MAX_DIM = 4096
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [rcm_pkg::PIXEL_W-1:0]       req_pixel_in,
   input  logic [rcm_pkg::COORD_W-1:0]       req_col,
   input  logic [rcm_pkg::COORD_W-1:0]       req_row,
   output logic                              rsp_valid,
   output logic [rcm_pkg::PIXEL_W-1:0]       rsp_pixel_out,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [rcm_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [rcm_pkg::CSR_DATA_W-1:0]    csr_data
);

   rcm_pkg::cfg_type cfg_ff, cfg_in;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            rcm_pkg::CSR_WIDTH:  cfg_in.width  = csr_data[rcm_pkg::DIM_W-1:0];
            rcm_pkg::CSR_HEIGHT: cfg_in.height = csr_data[rcm_pkg::DIM_W-1:0];
            rcm_pkg::CSR_RADIUS: cfg_in.radius = csr_data[rcm_pkg::RADIUS_W-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.width  <= rcm_pkg::WIDTH_RESET;
         cfg_ff.height <= rcm_pkg::HEIGHT_RESET;
         cfg_ff.radius <= rcm_pkg::RADIUS_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   rcm_pipe #(
      .MAX_DIM (MAX_DIM)
   ) u_pipe (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (start && !busy),
      .in_pixel  (req_pixel_in),
      .in_col    (req_col),
      .in_row    (req_row),
      .out_valid (rsp_valid),
      .out_pixel (rsp_pixel_out)
   );

endmodule
